[sv/imu_cal_pkg.sv]
// Shared types for the IMU offset calibration block.
// Used by the control, lane and top-level modules; depends on nothing.
package imu_cal_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned DegW   = 26;
  localparam int unsigned CorrW  = 17;
  localparam int unsigned SumW   = 22;
  localparam int unsigned AngSumW = 14;
  localparam int unsigned AngOffW = 9;
  localparam int unsigned FracW  = 16;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned InDataW = 144;
  localparam int unsigned OutDataW = 184;
  localparam int unsigned UserW  = 2;

  // Per-beat commands from the calibration control to every lane.
  typedef struct packed {
    logic g_clr;
    logic g_acc;
    logic g_load;
    logic a_clr;
    logic a_acc;
    logic a_load;
  } cal_ctl_t;

  // Status of the calibration control for the current input beat.
  typedef struct packed {
    logic g_done;
    logic a_done;
    logic busy;
  } cal_stat_t;

endpackage

[sv/imu_offset_calibration.sv]
// Top level of the IMU offset calibration block: three axis lanes, the
// calibration control and the merging output register. Depends on imu_cal_pkg.
//
// Channel  Dir  Beat content
// s_axis   in   tdata: 9 raw samples; tuser: calibration start flags
// m_axis   out  tdata: 3 angles in Q.16 degrees, 6 corrected values; tuser: done
//
// Samples are taken back to back unless stalled; each result is registered on
// its acceptance. Finishing a calibration blocks input while the lane dividers
// (one multiply stage, one sign stage) produce the new offsets.
// Reset clears all offsets and sums and leaves both calibrations idle.
// A stalled output beat holds its data and blocks the input until it is taken.
module imu_offset_calibration #(
  parameter int unsigned CAL_SAMPLES = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // raw_roll, raw_pitch, raw_yaw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
  // accel_x_raw, accel_y_raw, accel_z_raw (16 bits each)
  input  logic [imu_cal_pkg::InDataW-1:0]     s_axis_tdata,
  // start_gyro_cal, start_accel_cal
  input  logic [imu_cal_pkg::UserW-1:0]       s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // roll_deg, pitch_deg, yaw_deg (26 bits each), gyro_x_out, gyro_y_out,
  // gyro_z_out, accel_x_out, accel_y_out, accel_z_out (17 bits each), 4 zero bits
  output logic [imu_cal_pkg::OutDataW-1:0]    m_axis_tdata,
  // gyro_cal_done, accel_cal_done
  output logic [imu_cal_pkg::UserW-1:0]       m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);
  import imu_cal_pkg::*;

  cal_ctl_t  ctl;
  cal_stat_t stat;
  logic      s_fire;
  logic      out_vld_q, out_vld_d;
  logic [OutDataW-1:0] data_q, data_d;
  logic [UserW-1:0]    user_q;

  logic signed [DegW-1:0]  ang_deg [NumAxes];
  logic signed [CorrW-1:0] gyr_out [NumAxes];
  logic signed [CorrW-1:0] acc_out [NumAxes];

  assign s_axis_tready = (!out_vld_q || m_axis_tready) && !stat.busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  imu_cal_ctrl #(.CAL_SAMPLES(CAL_SAMPLES)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s_fire),
    .start_g_i (s_axis_tuser[0]),
    .start_a_i (s_axis_tuser[1]),
    .ctl_o     (ctl),
    .stat_o    (stat)
  );

  for (genvar i = 0; i < NumAxes; i++) begin : g_lane
    imu_cal_lane #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .ACC_SUM     (i < NumAxes - 1)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .ang_raw_i ($signed(s_axis_tdata[i*RawW +: RawW])),
      .gyr_raw_i ($signed(s_axis_tdata[(NumAxes+i)*RawW +: RawW])),
      .acc_raw_i ($signed(s_axis_tdata[(2*NumAxes+i)*RawW +: RawW])),
      .ang_deg_o (ang_deg[i]),
      .gyr_out_o (gyr_out[i]),
      .acc_out_o (acc_out[i])
    );
  end

  always_comb begin
    data_d = '0;
    for (int i = 0; i < NumAxes; i++) begin
      data_d[i*DegW +: DegW] = ang_deg[i];
      data_d[NumAxes*DegW + i*CorrW +: CorrW] = gyr_out[i];
      data_d[NumAxes*DegW + (NumAxes+i)*CorrW +: CorrW] = acc_out[i];
    end
    out_vld_d = out_vld_q;
    if (s_fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      data_q <= data_d;
      user_q <= {stat.a_done, stat.g_done};
    end
  end

  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tvalid = out_vld_q;

  a_gyro_fin_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && stat.g_done |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while gyro offsets were being divided");

  a_accel_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && stat.g_done |-> !ctl.a_acc && !ctl.a_clr && !stat.a_done)
    else $error("acceleration calibration ran on a gyro finishing beat");

  a_done_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (stat.g_done || stat.a_done) |=> m_axis_tvalid && (m_axis_tuser != '0))
    else $error("done flag lost on its output beat");

endmodule

[sv/imu_cal_div.sv]
// Two-stage divider of a signed sum by a constant, truncating toward zero.
// Multiplies the magnitude by a rounded-up reciprocal; no package dependency.
module imu_cal_div #(
  parameter int unsigned WIDTH   = 22,
  parameter int unsigned DIVISOR = 20
) (
  input  logic                    clk_i,
  input  logic signed [WIDTH-1:0] num_i,
  output logic signed [WIDTH-1:0] quo_o
);

  localparam int unsigned SH = WIDTH + $clog2(DIVISOR);
  localparam longint unsigned MulL = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
  localparam logic [SH:0] Mul = (SH+1)'(MulL);

  logic             neg;
  logic [WIDTH-1:0] mag;
  logic [WIDTH+SH:0] prod_d, prod_q;
  logic             neg_q;
  logic [WIDTH-1:0] mag_q;

  assign neg    = num_i[WIDTH-1];
  assign mag    = neg ? WIDTH'(-num_i) : WIDTH'(num_i);
  assign prod_d = (WIDTH+SH+1)'(mag) * (WIDTH+SH+1)'(Mul);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg;
  end

  assign mag_q = prod_q[SH +: WIDTH];
  assign quo_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

[sv/imu_cal_ctrl.sv]
// Calibration sequencing: sample counters, idle flags and divide timing.
// Depends on imu_cal_pkg for the command and status structs.
module imu_cal_ctrl #(
  parameter int unsigned CAL_SAMPLES = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  start_g_i,
  input  logic                  start_a_i,
  output imu_cal_pkg::cal_ctl_t  ctl_o,
  output imu_cal_pkg::cal_stat_t stat_o
);
  import imu_cal_pkg::*;

  localparam int unsigned CntW = $clog2(CAL_SAMPLES + 1);
  localparam logic [CntW-1:0] NCnt = CntW'(CAL_SAMPLES);

  logic            g_idle_q, g_idle_d, a_idle_q, a_idle_d;
  logic [CntW-1:0] g_cnt_q, g_cnt_d, a_cnt_q, a_cnt_d;
  logic [1:0]      g_fin_q, g_fin_d, a_fin_q, a_fin_d;
  logic            g_act, g_first, g_fin, a_act, a_run, a_first, a_fin, skip_a;

  always_comb begin
    g_act   = !g_idle_q || start_g_i;
    g_first = g_act && (g_cnt_q == '0);
    g_fin   = g_act && (g_cnt_q == NCnt);
    skip_a  = g_first || g_fin;
    a_act   = !a_idle_q || start_a_i;
    a_run   = a_act && !skip_a;
    a_first = a_run && (a_cnt_q == '0);
    a_fin   = a_run && (a_cnt_q == NCnt);

    g_idle_d = g_idle_q;
    g_cnt_d  = g_cnt_q;
    a_idle_d = a_idle_q;
    a_cnt_d  = a_cnt_q;
    if (fire_i) begin
      if (g_act) begin
        g_idle_d = g_fin;
        g_cnt_d  = g_fin ? '0 : g_cnt_q + 1'b1;
      end
      if (start_a_i) begin
        a_idle_d = 1'b0;
      end
      if (a_run) begin
        a_idle_d = a_fin;
        a_cnt_d  = a_fin ? '0 : a_cnt_q + 1'b1;
      end
    end
    g_fin_d = {g_fin_q[0], fire_i && g_fin};
    a_fin_d = {a_fin_q[0], fire_i && a_fin};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_idle_q <= 1'b1;
      a_idle_q <= 1'b1;
      g_cnt_q  <= '0;
      a_cnt_q  <= '0;
      g_fin_q  <= '0;
      a_fin_q  <= '0;
    end else begin
      g_idle_q <= g_idle_d;
      a_idle_q <= a_idle_d;
      g_cnt_q  <= g_cnt_d;
      a_cnt_q  <= a_cnt_d;
      g_fin_q  <= g_fin_d;
      a_fin_q  <= a_fin_d;
    end
  end

  always_comb begin
    ctl_o.g_clr  = fire_i && g_first;
    ctl_o.g_acc  = fire_i && g_act && !g_first;
    ctl_o.g_load = g_fin_q[1];
    ctl_o.a_clr  = fire_i && a_first;
    ctl_o.a_acc  = fire_i && a_run && !a_first;
    ctl_o.a_load = a_fin_q[1];
    stat_o.g_done = g_fin;
    stat_o.a_done = a_fin;
    stat_o.busy   = (|g_fin_q) || (|a_fin_q);
  end

endmodule

[sv/imu_cal_lane.sv]
// One axis lane: offset correction, calibration sums and offset dividers.
// Depends on imu_cal_pkg and imu_cal_div.
module imu_cal_lane #(
  parameter int unsigned CAL_SAMPLES = 20,
  parameter bit          ACC_SUM     = 1'b1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  imu_cal_pkg::cal_ctl_t                  ctl_i,
  input  logic signed [imu_cal_pkg::RawW-1:0]    ang_raw_i,
  input  logic signed [imu_cal_pkg::RawW-1:0]    gyr_raw_i,
  input  logic signed [imu_cal_pkg::RawW-1:0]    acc_raw_i,
  output logic signed [imu_cal_pkg::DegW-1:0]    ang_deg_o,
  output logic signed [imu_cal_pkg::CorrW-1:0]   gyr_out_o,
  output logic signed [imu_cal_pkg::CorrW-1:0]   acc_out_o
);
  import imu_cal_pkg::*;

  logic signed [AngOffW-1:0] ang_off_q, ang_off_d;
  logic signed [RawW-1:0]    gyr_off_q, gyr_off_d, acc_off_q, acc_off_d;
  logic signed [AngSumW-1:0] ang_sum_q, ang_sum_d, ang_quo;
  logic signed [SumW-1:0]    gyr_sum_q, gyr_sum_d, gyr_quo;
  logic signed [AngSumW+FracW:0] ang_s;
  logic signed [AngSumW:0]   ang_trunc;

  assign ang_deg_o = DegW'(ang_raw_i) * DegW'(360)
                   - DegW'($signed({ang_off_q, {FracW{1'b0}}}));
  assign gyr_out_o = CorrW'(gyr_raw_i) - CorrW'(gyr_off_q);
  assign acc_out_o = CorrW'(acc_raw_i) - CorrW'(acc_off_q);

  // Angle sums keep whole degrees; the running total is cut toward zero.
  always_comb begin
    ang_s = (AngSumW+FracW+1)'($signed({ang_sum_q, {FracW{1'b0}}}))
          + (AngSumW+FracW+1)'(ang_deg_o);
    ang_trunc = ang_s[AngSumW+FracW:FracW]
              + (((ang_s[AngSumW+FracW] == 1'b1) && (ang_s[FracW-1:0] != '0))
                 ? (AngSumW+1)'(1) : (AngSumW+1)'(0));
  end

  imu_cal_div #(.WIDTH(SumW), .DIVISOR(CAL_SAMPLES)) u_gyr_div (
    .clk_i (clk_i),
    .num_i (gyr_sum_q),
    .quo_o (gyr_quo)
  );

  imu_cal_div #(.WIDTH(AngSumW), .DIVISOR(CAL_SAMPLES)) u_ang_div (
    .clk_i (clk_i),
    .num_i (ang_sum_q),
    .quo_o (ang_quo)
  );

  always_comb begin
    gyr_sum_d = gyr_sum_q;
    ang_sum_d = ang_sum_q;
    gyr_off_d = gyr_off_q;
    ang_off_d = ang_off_q;
    if (ctl_i.g_clr) begin
      gyr_sum_d = '0;
      ang_sum_d = '0;
      gyr_off_d = '0;
      ang_off_d = '0;
    end else if (ctl_i.g_acc) begin
      gyr_sum_d = gyr_sum_q + SumW'(gyr_out_o);
      ang_sum_d = AngSumW'(ang_trunc);
    end
    if (ctl_i.g_load) begin
      gyr_off_d = RawW'(gyr_quo);
      ang_off_d = AngOffW'(ang_quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyr_sum_q <= '0;
      ang_sum_q <= '0;
      gyr_off_q <= '0;
      ang_off_q <= '0;
      acc_off_q <= '0;
    end else begin
      gyr_sum_q <= gyr_sum_d;
      ang_sum_q <= ang_sum_d;
      gyr_off_q <= gyr_off_d;
      ang_off_q <= ang_off_d;
      acc_off_q <= acc_off_d;
    end
  end

  if (ACC_SUM) begin : g_acc_sum
    logic signed [SumW-1:0] acc_sum_q, acc_sum_d, acc_quo;

    imu_cal_div #(.WIDTH(SumW), .DIVISOR(CAL_SAMPLES)) u_acc_div (
      .clk_i (clk_i),
      .num_i (acc_sum_q),
      .quo_o (acc_quo)
    );

    always_comb begin
      acc_sum_d = acc_sum_q;
      acc_off_d = acc_off_q;
      if (ctl_i.a_clr) begin
        acc_sum_d = '0;
        acc_off_d = '0;
      end else if (ctl_i.a_acc) begin
        acc_sum_d = acc_sum_q + SumW'(acc_out_o);
      end
      if (ctl_i.a_load) begin
        acc_off_d = RawW'(acc_quo);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_sum_q <= '0;
      end else begin
        acc_sum_q <= acc_sum_d;
      end
    end
  end else begin : g_no_acc_sum
    // This axis is not averaged; its offset is cleared on every accel calibration beat and on load.
    always_comb begin
      acc_off_d = acc_off_q;
      if (ctl_i.a_clr || ctl_i.a_load || ctl_i.a_acc) begin
        acc_off_d = '0;
      end
    end
  end

endmodule
